// ===== hdl/udmn_pkg.sv =====
// Package for the unsigned division magic number block.
// Holds the shared constants, the controller state type and the command and
// status structs between controller and datapath. Depends on nothing.
package udmn_pkg;

   localparam int WIDTH_DEFAULT = 16;
   localparam int SHIFT_W       = 5;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START,
      ST_DIV_MOD,
      ST_INIT_Q1,
      ST_DIV_Q1,
      ST_INIT_Q2,
      ST_DIV_Q2,
      ST_SAVE_Q2,
      ST_ROUND,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      DIV_MOD,
      DIV_Q1,
      DIV_Q2
   } div_sel_type;

   typedef enum logic [1:0] {
      SAVE_NONE,
      SAVE_NC,
      SAVE_Q1,
      SAVE_Q2
   } save_sel_type;

   typedef struct packed {
      logic         load;
      logic         div_init;
      div_sel_type  div_sel;
      logic         div_step;
      save_sel_type save_sel;
      logic         round_step;
      logic         out_load;
   } cmd_type;

   typedef struct packed {
      logic divisor_zero;
      logic round_stop;
   } status_type;

endpackage

// ===== hdl/udmn_ctrl.sv =====
// Controller state machine of the magic number block.
// Sequences the three divisions, the quotient rounds and the result hand-off.
// Depends on udmn_pkg.
module udmn_ctrl #(
   parameter int WIDTH = udmn_pkg::WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  udmn_pkg::status_type   status,
   output udmn_pkg::cmd_type      cmd
);

   localparam int CW = $clog2(WIDTH);

   udmn_pkg::state_type state_ff, state_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                last;
   logic                out_free;

   assign last     = (cnt_ff == CW'(WIDTH - 1));
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         udmn_pkg::ST_IDLE: begin
            if (req_valid) state_in = udmn_pkg::ST_START;
         end
         udmn_pkg::ST_START: begin
            if (status.divisor_zero) state_in = udmn_pkg::ST_FINISH;
            else                     state_in = udmn_pkg::ST_DIV_MOD;
         end
         udmn_pkg::ST_DIV_MOD: begin
            if (last) state_in = udmn_pkg::ST_INIT_Q1;
         end
         udmn_pkg::ST_INIT_Q1: state_in = udmn_pkg::ST_DIV_Q1;
         udmn_pkg::ST_DIV_Q1: begin
            if (last) state_in = udmn_pkg::ST_INIT_Q2;
         end
         udmn_pkg::ST_INIT_Q2: state_in = udmn_pkg::ST_DIV_Q2;
         udmn_pkg::ST_DIV_Q2: begin
            if (last) state_in = udmn_pkg::ST_SAVE_Q2;
         end
         udmn_pkg::ST_SAVE_Q2: state_in = udmn_pkg::ST_ROUND;
         udmn_pkg::ST_ROUND: begin
            if (status.round_stop) state_in = udmn_pkg::ST_FINISH;
         end
         udmn_pkg::ST_FINISH: begin
            if (out_free) state_in = udmn_pkg::ST_IDLE;
         end
         default: state_in = udmn_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd            = '0;
      cmd.div_sel    = udmn_pkg::DIV_MOD;
      cmd.save_sel   = udmn_pkg::SAVE_NONE;
      req_stall      = 1'b1;
      unique case (state_ff)
         udmn_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         udmn_pkg::ST_START: begin
            cmd.div_init = 1'b1;
            cmd.div_sel  = udmn_pkg::DIV_MOD;
         end
         udmn_pkg::ST_DIV_MOD, udmn_pkg::ST_DIV_Q1, udmn_pkg::ST_DIV_Q2: begin
            cmd.div_step = 1'b1;
         end
         udmn_pkg::ST_INIT_Q1: begin
            cmd.div_init = 1'b1;
            cmd.div_sel  = udmn_pkg::DIV_Q1;
            cmd.save_sel = udmn_pkg::SAVE_NC;
         end
         udmn_pkg::ST_INIT_Q2: begin
            cmd.div_init = 1'b1;
            cmd.div_sel  = udmn_pkg::DIV_Q2;
            cmd.save_sel = udmn_pkg::SAVE_Q1;
         end
         udmn_pkg::ST_SAVE_Q2: begin
            cmd.save_sel = udmn_pkg::SAVE_Q2;
         end
         udmn_pkg::ST_ROUND: begin
            cmd.round_step = !status.round_stop;
         end
         udmn_pkg::ST_FINISH: begin
            cmd.out_load = out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_comb begin
      if (state_ff == udmn_pkg::ST_DIV_MOD || state_ff == udmn_pkg::ST_DIV_Q1 ||
          state_ff == udmn_pkg::ST_DIV_Q2) begin
         cnt_in = cnt_ff + 1'b1;
      end else begin
         cnt_in = '0;
      end
   end

   always_comb begin
      if (state_ff == udmn_pkg::ST_FINISH && out_free) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= udmn_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hdl/udmn_dp.sv =====
// Datapath of the magic number block: restoring divider, quotient rounds and
// the result register. Driven by udmn_ctrl through udmn_pkg::cmd_type.
// Depends on udmn_pkg.
module udmn_dp #(
   parameter int WIDTH = udmn_pkg::WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic [WIDTH-1:0]              req_divisor,
   input  udmn_pkg::cmd_type             cmd,
   output udmn_pkg::status_type          status,
   output logic [WIDTH-1:0]              rsp_magic,
   output logic                          rsp_add_flag,
   output logic [udmn_pkg::SHIFT_W-1:0]  rsp_shift_amount
);

   localparam int PW = $clog2(2 * WIDTH + 1);
   localparam logic [WIDTH-1:0] MASK    = '1;
   localparam logic [WIDTH-1:0] HALF    = {1'b1, {(WIDTH - 1){1'b0}}};
   localparam logic [WIDTH-1:0] HALF_M1 = {1'b0, {(WIDTH - 1){1'b1}}};

   logic [WIDTH-1:0] d_ff, d_in;
   logic [WIDTH-1:0] div_rem_ff, div_rem_in;
   logic [WIDTH-1:0] div_quo_ff, div_quo_in;
   logic [WIDTH-1:0] div_den_ff, div_den_in;
   logic [WIDTH-1:0] nc_ff, nc_in;
   logic [WIDTH-1:0] q1_ff, q1_in;
   logic [WIDTH-1:0] r1_ff, r1_in;
   logic [WIDTH-1:0] q2_ff, q2_in;
   logic [WIDTH-1:0] r2_ff, r2_in;
   logic             addf_ff, addf_in;
   logic [PW-1:0]    p_ff, p_in;
   logic [WIDTH-1:0]             magic_ff, magic_in;
   logic                         add_ff, add_in;
   logic [udmn_pkg::SHIFT_W-1:0] shift_ff, shift_in;

   logic [WIDTH:0]   div_trial, div_diff;
   logic             div_ge;
   logic [WIDTH-1:0] nc_calc;
   logic [WIDTH:0]   r1_dbl, r1_sub, r2_dbl, r2_sub;
   logic             ge1, ge2;
   logic [WIDTH-1:0] delta;
   logic             keep_going;
   logic [PW-1:0]    shift_full;

   assign div_trial = {div_rem_ff, div_quo_ff[WIDTH-1]};
   assign div_diff  = div_trial - {1'b0, div_den_ff};
   assign div_ge    = (div_trial >= {1'b0, div_den_ff});
   assign nc_calc   = MASK - div_rem_ff;

   assign r1_dbl = {r1_ff, 1'b0};
   assign r1_sub = r1_dbl - {1'b0, nc_ff};
   assign ge1    = (r1_dbl >= {1'b0, nc_ff});
   assign r2_dbl = {r2_ff, 1'b1};
   assign r2_sub = r2_dbl - {1'b0, d_ff};
   assign ge2    = (r2_dbl >= {1'b0, d_ff});

   assign delta      = d_ff - 1'b1 - r2_ff;
   assign keep_going = (p_ff < PW'(2 * WIDTH)) &&
                       ((q1_ff < delta) || ((q1_ff == delta) && (r1_ff == '0)));

   assign status.divisor_zero = (d_ff == '0);
   assign status.round_stop   = (p_ff != PW'(WIDTH - 1)) && !keep_going;

   assign shift_full = p_ff - PW'(WIDTH);

   always_comb begin
      d_in       = d_ff;
      div_rem_in = div_rem_ff;
      div_quo_in = div_quo_ff;
      div_den_in = div_den_ff;
      nc_in      = nc_ff;
      q1_in      = q1_ff;
      r1_in      = r1_ff;
      q2_in      = q2_ff;
      r2_in      = r2_ff;
      addf_in    = addf_ff;
      p_in       = p_ff;
      magic_in   = magic_ff;
      add_in     = add_ff;
      shift_in   = shift_ff;

      if (cmd.load) d_in = req_divisor;

      if (cmd.div_init) begin
         div_rem_in = '0;
         unique case (cmd.div_sel)
            udmn_pkg::DIV_MOD: begin
               div_quo_in = '0 - d_ff;
               div_den_in = d_ff;
            end
            udmn_pkg::DIV_Q1: begin
               div_quo_in = HALF;
               div_den_in = nc_calc;
            end
            udmn_pkg::DIV_Q2: begin
               div_quo_in = HALF_M1;
               div_den_in = d_ff;
            end
            default: begin
               div_quo_in = div_quo_ff;
            end
         endcase
      end else if (cmd.div_step) begin
         div_rem_in = div_ge ? div_diff[WIDTH-1:0] : div_trial[WIDTH-1:0];
         div_quo_in = {div_quo_ff[WIDTH-2:0], div_ge};
      end

      unique case (cmd.save_sel)
         udmn_pkg::SAVE_NONE: begin
            nc_in = nc_ff;
         end
         udmn_pkg::SAVE_NC: begin
            nc_in = nc_calc;
         end
         udmn_pkg::SAVE_Q1: begin
            q1_in = div_quo_ff;
            r1_in = div_rem_ff;
         end
         udmn_pkg::SAVE_Q2: begin
            q2_in   = div_quo_ff;
            r2_in   = div_rem_ff;
            addf_in = 1'b0;
            p_in    = PW'(WIDTH - 1);
         end
         default: begin
            nc_in = nc_ff;
         end
      endcase

      if (cmd.round_step) begin
         p_in  = p_ff + 1'b1;
         q1_in = {q1_ff[WIDTH-2:0], ge1};
         r1_in = ge1 ? r1_sub[WIDTH-1:0] : r1_dbl[WIDTH-1:0];
         if (ge2) begin
            if (q2_ff >= HALF_M1) addf_in = 1'b1;
            r2_in = r2_sub[WIDTH-1:0];
         end else begin
            if (q2_ff >= HALF) addf_in = 1'b1;
            r2_in = r2_dbl[WIDTH-1:0];
         end
         q2_in = {q2_ff[WIDTH-2:0], ge2};
      end

      if (cmd.out_load) begin
         if (status.divisor_zero) begin
            magic_in = '0;
            add_in   = 1'b0;
            shift_in = '0;
         end else begin
            magic_in = q2_ff + 1'b1;
            add_in   = addf_ff;
            shift_in = shift_full[udmn_pkg::SHIFT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      d_ff       <= d_in;
      div_rem_ff <= div_rem_in;
      div_quo_ff <= div_quo_in;
      div_den_ff <= div_den_in;
      nc_ff      <= nc_in;
      q1_ff      <= q1_in;
      r1_ff      <= r1_in;
      q2_ff      <= q2_in;
      r2_ff      <= r2_in;
      addf_ff    <= addf_in;
      p_ff       <= p_in;
      magic_ff   <= magic_in;
      add_ff     <= add_in;
      shift_ff   <= shift_in;
   end

   assign rsp_magic        = magic_ff;
   assign rsp_add_flag     = add_ff;
   assign rsp_shift_amount = shift_ff;

endmodule

// ===== hdl/unsigned_div_magic_number_16.sv =====
// Top level of the unsigned division magic number block.
// Joins the controller udmn_ctrl and the datapath udmn_dp; depends on udmn_pkg.
//
// A word on the req channel carries a divisor. A word on the rsp channel
// carries the magic multiplier, the add flag and the post-shift for it,
// so that x / d equals ((hi(x * magic) + (add_flag ? x : 0)) >> shift_amount).
// Both channels move a word when valid is high and stall is low.
// One divisor is worked on at a time; req_stall is low only while idle.
// After a divisor is taken, the block runs three divisions on one shared
// restoring divider that makes one quotient bit per cycle, then a round loop
// that adds one quotient bit per cycle for 1 to WIDTH + 1 quotient rounds,
// and then loads the result register. A zero divisor returns all zeros.
// While a result waits in the output register under rsp_stall, the next
// divisor is taken and worked on; its result waits until the register frees.
// A synchronous reset returns the controller to idle and drops rsp_valid.
module unsigned_div_magic_number_16 #(
   parameter int WIDTH = udmn_pkg::WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [WIDTH-1:0]              req_divisor,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [WIDTH-1:0]              rsp_magic,
   output logic                          rsp_add_flag,
   output logic [udmn_pkg::SHIFT_W-1:0]  rsp_shift_amount
);

   udmn_pkg::cmd_type    cmd;
   udmn_pkg::status_type status;

   udmn_ctrl #(
      .WIDTH(WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   udmn_dp #(
      .WIDTH(WIDTH)
   ) u_dp (
      .clock            (clock),
      .req_divisor      (req_divisor),
      .cmd              (cmd),
      .status           (status),
      .rsp_magic        (rsp_magic),
      .rsp_add_flag     (rsp_add_flag),
      .rsp_shift_amount (rsp_shift_amount)
   );

endmodule
